// ===== hdl/sih_pkg.sv =====
// Package for the string intern hash table: payload structs, status codes,
// controller-to-datapath command and status structs. No dependencies.
`default_nettype none
package sih_pkg;
	localparam int unsigned MapSlotsDef    = 1024;
	localparam int unsigned RegionBytesDef = 65536;
	localparam int unsigned MaxStringDef   = 256;
	localparam int unsigned ProbeLimitDef  = 3;
	localparam int unsigned HashBytes      = 8;

	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_FOUND    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_EXHAUST  = 3'd3;
	localparam logic [2:0] ST_TOO_LONG = 3'd4;

	localparam logic [0:0] REG_SLOT_LOG2 = 1'd0;
	localparam logic [0:0] REG_CAPACITY  = 1'd1;

	typedef struct packed {
		logic [63:0] key_hash;
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        is_last;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [16:0] entry_offset;
		logic [31:0] insert_total;
	} out_item_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_CLEAR,
		CMD_START,
		CMD_SLOT_RD,
		CMD_SLOT_EVAL,
		CMD_CMP_RD,
		CMD_CMP_EVAL,
		CMD_WR_ENTRY,
		CMD_WR_SLOT,
		CMD_NEXT_PROBE,
		CMD_FINISH
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [2:0] status;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic overflow;
		logic cap_fail;
		logic slot_empty;
		logic tag_hit;
		logic span_ok;
		logic cmp_mismatch;
		logic cmp_done;
		logic wr_done;
		logic probes_left;
	} stat_t;
endpackage
`default_nettype wire

// ===== hdl/string_intern_hash_table.sv =====
// Top level of the string intern hash table: APB registers and the
// controller/datapath pair. Depends on sih_pkg, sih_ctrl, sih_datapath.
//
// Usage: one input transaction carries one string byte (or an empty marker)
// with the string's 64-bit hash; the transaction with is_last set starts a
// lookup. Bytes are taken one per cycle while no lookup runs. A lookup
// passes a check step and a finish step; each probe reads its slot and
// evaluates it, and a probe that misses adds a fail step; a tag hit
// compares stored hash and string byte by byte; an insert writes hash and
// string, one region byte per cycle, then the slot. A too long or full
// answer takes only the check and finish steps.
// One result transaction follows each is_last; while out_stall holds the
// output register, the next string still streams in and its result waits.
// After reset the slot table is cleared, one slot per cycle, with in_stall
// high; register writes work throughout.
`default_nettype none
module string_intern_hash_table #(
	parameter int unsigned MAP_SLOTS    = sih_pkg::MapSlotsDef,
	parameter int unsigned REGION_BYTES = sih_pkg::RegionBytesDef,
	parameter int unsigned MAX_STRING   = sih_pkg::MaxStringDef,
	parameter int unsigned PROBE_LIMIT  = sih_pkg::ProbeLimitDef
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_stall,
	input  wire sih_pkg::in_item_t in_data,
	output logic                   out_valid,
	input  wire                    out_stall,
	output sih_pkg::out_item_t     out_data,
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire [2:0]              paddr,
	input  wire [31:0]             pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import sih_pkg::*;
	logic [3:0]  slot_log2_q;
	logic [16:0] capacity_q;
	cmd_t        cmd;
	stat_t       stat;
	out_item_t   result;
	logic        in_take;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_log2_q <= 4'd10;
			capacity_q <= 17'd65536;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_SLOT_LOG2)
				slot_log2_q <= pwdata[3:0];
			else
				capacity_q <= pwdata[16:0];
		end
	end
	assign prdata = (paddr[2] == REG_SLOT_LOG2) ? {28'd0, slot_log2_q} : {15'd0, capacity_q};

	sih_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_item(in_data),
		.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
		.out_item(out_data), .result(result), .stat(stat), .cmd(cmd), .in_take(in_take)
	);

	sih_datapath #(
		.MAP_SLOTS(MAP_SLOTS), .REGION_BYTES(REGION_BYTES),
		.MAX_STRING(MAX_STRING), .PROBE_LIMIT(PROBE_LIMIT)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .in_item(in_data), .in_take(in_take), .cmd(cmd),
		.slot_count_log2(slot_log2_q), .region_capacity(capacity_q),
		.stat(stat), .result(result)
	);
endmodule
`default_nettype wire

// ===== hdl/sih_datapath.sv =====
// Datapath of the string intern hash table: string buffer, slot table,
// data region, counters. Depends on sih_pkg; driven by sih_ctrl.
`default_nettype none
module sih_datapath #(
	parameter int unsigned MAP_SLOTS    = sih_pkg::MapSlotsDef,
	parameter int unsigned REGION_BYTES = sih_pkg::RegionBytesDef,
	parameter int unsigned MAX_STRING   = sih_pkg::MaxStringDef,
	parameter int unsigned PROBE_LIMIT  = sih_pkg::ProbeLimitDef
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire sih_pkg::in_item_t in_item,
	input  wire                  in_take,
	input  wire sih_pkg::cmd_t   cmd,
	input  wire [3:0]            slot_count_log2,
	input  wire [16:0]           region_capacity,
	output sih_pkg::stat_t       stat,
	output sih_pkg::out_item_t   result
);
	import sih_pkg::*;
	localparam int SW = (MAP_SLOTS > 1) ? $clog2(MAP_SLOTS) : 1;
	localparam int RW = $clog2(REGION_BYTES);
	localparam int BW = $clog2(MAX_STRING);
	localparam int LW = BW + 1;
	localparam int PW = $clog2(PROBE_LIMIT + 1);
	localparam int FW = 18;

	logic [31:0] slot_mem [MAP_SLOTS];
	logic [7:0]  region_mem [REGION_BYTES];
	logic [7:0]  buf_mem [MAX_STRING];

	logic [63:0] hash_q;
	logic [LW-1:0] len_q;
	logic        ovf_q;
	logic [FW-1:0] fill_q;
	logic [31:0] count_q;
	logic [SW-1:0] clr_q;
	logic        clr_done_q;
	logic [SW-1:0] idx_q;
	logic [PW-1:0] hop_q;
	logic [31:0] slot_s1;
	logic [7:0]  reg_rd_s1;
	logic [7:0]  buf_rd_s1;
	logic [LW+3:0] pos_q;
	logic        mism_q;
	logic [FW-1:0] off_q;
	logic [FW-1:0] base_q;
	logic [LW+3:0] wpos_q;
	logic [LW+3:0] total;
	logic [SW-1:0] mask;
	logic [4:0]  lg;
	logic [16:0] cap;
	logic [FW-1:0] fill_need;
	logic [7:0]  hash_byte_cmp;
	logic [7:0]  hash_byte_wr;
	logic [7:0]  cmp_byte;
	logic [7:0]  wr_byte_s1;
	logic [RW-1:0] wr_addr_s1;
	logic        wr_en_s1;
	logic [FW-1:0] rd_addr;
	logic [FW-1:0] wr_addr;
	logic [FW-1:0] span_end;

	assign total = (LW+4)'(len_q) + (LW+4)'(HashBytes);
	assign lg = (slot_count_log2 == 4'd0) ? 5'd1 : {1'b0, slot_count_log2};
	always_comb begin
		if (lg >= 5'(SW))
			mask = '1;
		else
			mask = SW'((32'd1 << lg) - 32'd1);
	end
	assign cap = (region_capacity > 17'(REGION_BYTES)) ? 17'(REGION_BYTES) : region_capacity;
	assign fill_need = fill_q + FW'(total);
	assign span_end = base_q + FW'(total);
	assign hash_byte_cmp = hash_q[pos_q[2:0]*8 +: 8];
	assign hash_byte_wr = hash_q[wpos_q[2:0]*8 +: 8];
	assign rd_addr = base_q + FW'(pos_q);
	assign wr_addr = fill_q + FW'(wpos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ovf_q <= 1'b0;
			hash_q <= '0;
			fill_q <= '0;
			count_q <= '0;
			clr_q <= '0;
			clr_done_q <= 1'b0;
			idx_q <= '0;
			hop_q <= '0;
			pos_q <= '0;
			wpos_q <= '0;
			mism_q <= 1'b0;
			wr_en_s1 <= 1'b0;
		end else begin
			wr_en_s1 <= cmd.op == CMD_WR_ENTRY;
			if (in_take) begin
				if (len_q == '0 && !ovf_q)
					hash_q <= in_item.key_hash;
				if (in_item.has_byte) begin
					if (len_q < LW'(MAX_STRING))
						len_q <= len_q + 1'b1;
					else
						ovf_q <= 1'b1;
				end
			end
			case (cmd.op)
				CMD_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(MAP_SLOTS - 1))
						clr_done_q <= 1'b1;
				end
				CMD_START: begin
					idx_q <= SW'(hash_q) & mask;
					hop_q <= '0;
				end
				CMD_SLOT_EVAL: begin
					pos_q <= '0;
					wpos_q <= '0;
					mism_q <= 1'b0;
				end
				CMD_CMP_RD: pos_q <= pos_q + 1'b1;
				CMD_CMP_EVAL: begin
					if (cmp_byte != buf_rd_s1)
						mism_q <= 1'b1;
				end
				CMD_WR_ENTRY: wpos_q <= wpos_q + 1'b1;
				CMD_WR_SLOT: begin
					fill_q <= fill_need;
					count_q <= count_q + 1'b1;
				end
				CMD_NEXT_PROBE: begin
					idx_q <= (idx_q + 1'b1) & mask;
					hop_q <= hop_q + 1'b1;
				end
				CMD_FINISH: begin
					len_q <= '0;
					ovf_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign cmp_byte = reg_rd_s1;
	assign base_q = FW'(slot_s1[31:16]);
	assign off_q = base_q + FW'(HashBytes);

	always_ff @(posedge clk) begin
		if (in_take && in_item.has_byte && len_q < LW'(MAX_STRING))
			buf_mem[len_q[BW-1:0]] <= in_item.data_byte;
		if (cmd.op == CMD_CLEAR)
			slot_mem[clr_q] <= '0;
		else if (cmd.op == CMD_WR_SLOT)
			slot_mem[idx_q] <= {fill_q[15:0], hash_q[15:0]};
		if (cmd.op == CMD_SLOT_RD)
			slot_s1 <= slot_mem[idx_q];
		if (cmd.op == CMD_CMP_RD) begin
			reg_rd_s1 <= region_mem[rd_addr[RW-1:0]];
			buf_rd_s1 <= (pos_q < (LW+4)'(HashBytes)) ? hash_byte_cmp :
				buf_mem[BW'(pos_q - (LW+4)'(HashBytes))];
		end
		if (cmd.op == CMD_WR_ENTRY) begin
			wr_byte_s1 <= (wpos_q < (LW+4)'(HashBytes)) ? hash_byte_wr :
				buf_mem[BW'(wpos_q - (LW+4)'(HashBytes))];
			wr_addr_s1 <= wr_addr[RW-1:0];
		end
		if (wr_en_s1)
			region_mem[wr_addr_s1] <= wr_byte_s1;
	end

	assign stat.clear_done   = clr_done_q;
	assign stat.overflow     = ovf_q;
	assign stat.cap_fail     = fill_need > FW'(cap);
	assign stat.slot_empty   = slot_s1 == 32'd0;
	assign stat.tag_hit      = slot_s1[15:0] == hash_q[15:0];
	assign stat.span_ok      = span_end <= fill_q;
	assign stat.cmp_mismatch = mism_q;
	assign stat.cmp_done     = pos_q == total;
	assign stat.wr_done      = wpos_q == total;
	assign stat.probes_left  = hop_q < PW'(PROBE_LIMIT - 1);

	always_comb begin
		result.status = cmd.status;
		result.insert_total = count_q;
		case (cmd.status)
			ST_INSERTED: result.entry_offset = 17'(fill_q - FW'(total) + FW'(HashBytes));
			ST_FOUND:    result.entry_offset = 17'(off_q);
			default:     result.entry_offset = '0;
		endcase
	end
endmodule
`default_nettype wire

// ===== hdl/sih_ctrl.sv =====
// Controller of the string intern hash table: clearing pass, probe sequence,
// compare and insert steps, output register. Depends on sih_pkg.
`default_nettype none
module sih_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	input  wire sih_pkg::in_item_t in_item,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire                   out_stall,
	output sih_pkg::out_item_t    out_item,
	input  wire sih_pkg::out_item_t result,
	input  wire sih_pkg::stat_t   stat,
	output sih_pkg::cmd_t         cmd,
	output logic                  in_take
);
	import sih_pkg::*;
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_SLOT_RD, S_SLOT_EVAL, S_CMP_RD, S_CMP_EVAL,
		S_CMP_END, S_WR, S_WR_SLOT, S_DONE, S_FAIL
	} state_t;
	state_t state_q;
	logic [2:0] status_q;
	logic       busy;
	logic       out_free;

	assign busy = state_q != S_IDLE;
	assign out_free = !out_valid || !out_stall;
	assign in_stall = busy;
	assign in_take = in_valid && !in_stall;

	always_comb begin
		cmd.status = status_q;
		case (state_q)
			S_CLEAR:     cmd.op = CMD_CLEAR;
			S_CHECK:     cmd.op = CMD_START;
			S_SLOT_RD:   cmd.op = CMD_SLOT_RD;
			S_SLOT_EVAL: cmd.op = CMD_SLOT_EVAL;
			S_CMP_RD:    cmd.op = CMD_CMP_RD;
			S_CMP_EVAL:  cmd.op = CMD_CMP_EVAL;
			S_WR:        cmd.op = stat.wr_done ? CMD_NONE : CMD_WR_ENTRY;
			S_WR_SLOT:   cmd.op = CMD_WR_SLOT;
			S_DONE:      cmd.op = out_free ? CMD_FINISH : CMD_NONE;
			S_FAIL:      cmd.op = stat.probes_left ? CMD_NEXT_PROBE : CMD_NONE;
			default:     cmd.op = CMD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			status_q <= ST_EXHAUST;
			out_valid <= 1'b0;
			out_item <= '0;
		end else begin
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				S_CLEAR: if (stat.clear_done) state_q <= S_IDLE;
				S_IDLE: if (in_take && in_item.is_last) state_q <= S_CHECK;
				S_CHECK: begin
					if (stat.overflow) begin
						status_q <= ST_TOO_LONG;
						state_q <= S_DONE;
					end else if (stat.cap_fail) begin
						status_q <= ST_FULL;
						state_q <= S_DONE;
					end else
						state_q <= S_SLOT_RD;
				end
				S_SLOT_RD: state_q <= S_SLOT_EVAL;
				S_SLOT_EVAL: begin
					if (stat.slot_empty)
						state_q <= S_WR;
					else if (stat.tag_hit && stat.span_ok)
						state_q <= S_CMP_RD;
					else
						state_q <= S_FAIL;
				end
				S_CMP_RD: state_q <= S_CMP_EVAL;
				S_CMP_EVAL: state_q <= stat.cmp_done ? S_CMP_END : S_CMP_RD;
				S_CMP_END: begin
					if (stat.cmp_mismatch)
						state_q <= S_FAIL;
					else begin
						status_q <= ST_FOUND;
						state_q <= S_DONE;
					end
				end
				S_WR: if (stat.wr_done) state_q <= S_WR_SLOT;
				S_WR_SLOT: begin
					status_q <= ST_INSERTED;
					state_q <= S_DONE;
				end
				S_FAIL: begin
					if (stat.probes_left)
						state_q <= S_SLOT_RD;
					else begin
						status_q <= ST_EXHAUST;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						out_item <= result;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for string_intern_hash_table: streams strings with their hashes and checks
// every lookup answer against an in-bench interning model. Depends on sih_pkg.
// Covers several slot-count and capacity settings, random idling and a long output hold.
`timescale 1ns / 100ps
module testbench;
	import sih_pkg::*;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	in_item_t    in_data   = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic [31:0] prdata;
	logic        pready;

	string_intern_hash_table dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [31:0] slot_mirror [1024];
	logic [7:0]  region_mirror [65536];
	logic [7:0]  str_buf [256];
	int unsigned fill_lvl = 0;
	int unsigned str_len = 0;
	logic [31:0] insert_cnt = '0;
	bit          str_over = 1'b0;
	logic [63:0] cur_hash = '0;
	logic [3:0]  log2_cfg = 4'd10;
	logic [16:0] cap_cfg = 17'd65536;
	out_item_t   lookup_q [$];
	in_item_t    feed_q [$];
	int          mismatches = 0;

	function automatic bit stored_match(input logic [31:0] off);
		if (off + 8 + str_len > fill_lvl)
			return 1'b0;
		for (int i = 0; i < 8; i++)
			if (region_mirror[off + i] != cur_hash[8*i +: 8])
				return 1'b0;
		for (int i = 0; i < str_len; i++)
			if (region_mirror[off + 8 + i] != str_buf[i])
				return 1'b0;
		return 1'b1;
	endfunction

	task automatic intern_lookup(output out_item_t r);
		logic [31:0] lg, n, idx, cap, off;
		bit          done;
		r = '0;
		r.status = ST_EXHAUST;
		done = 1'b0;
		lg = (log2_cfg == 0) ? 1 : log2_cfg;
		n = 32'd1 << lg;
		if (n > 1024)
			n = 1024;
		idx = cur_hash[31:0] & (n - 1);
		cap = (cap_cfg > 65536) ? 65536 : cap_cfg;
		if (str_over) begin
			r.status = ST_TOO_LONG;
		end else if (fill_lvl + str_len + 8 > cap) begin
			r.status = ST_FULL;
		end else begin
			for (int hop = 0; hop < 3 && !done; hop++) begin
				if (slot_mirror[idx] == 0) begin
					off = fill_lvl;
					slot_mirror[idx] = {off[15:0], cur_hash[15:0]};
					for (int i = 0; i < 8; i++)
						region_mirror[off + i] = cur_hash[8*i +: 8];
					for (int i = 0; i < str_len; i++)
						region_mirror[off + 8 + i] = str_buf[i];
					fill_lvl = off + str_len + 8;
					insert_cnt++;
					r.status = ST_INSERTED;
					r.entry_offset = 17'(off + 8);
					done = 1'b1;
				end else if (slot_mirror[idx][15:0] == cur_hash[15:0] &&
						stored_match({16'd0, slot_mirror[idx][31:16]})) begin
					r.status = ST_FOUND;
					r.entry_offset = 17'(slot_mirror[idx][31:16]) + 17'd8;
					done = 1'b1;
				end else begin
					idx = (idx + 1) & (n - 1);
				end
			end
		end
		r.insert_total = insert_cnt;
	endtask

	task automatic take_item(input in_item_t it);
		out_item_t r;
		if (str_len == 0 && !str_over)
			cur_hash = it.key_hash;
		if (it.has_byte) begin
			if (str_len < 256) begin
				str_buf[str_len] = it.data_byte;
				str_len++;
			end else begin
				str_over = 1'b1;
			end
		end
		if (it.is_last) begin
			intern_lookup(r);
			lookup_q.push_back(r);
			str_len = 0;
			str_over = 1'b0;
		end
	endtask

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t want;
		if (lookup_q.size() == 0) begin
			report("result transaction with no lookup pending");
			return;
		end
		want = lookup_q.pop_front();
		if (got.status != want.status)
			report($sformatf("status %0d, want %0d", got.status, want.status));
		if (got.entry_offset != want.entry_offset)
			report($sformatf("entry_offset %0d, want %0d", got.entry_offset,
				want.entry_offset));
		if (got.insert_total != want.insert_total)
			report($sformatf("insert_total %0d, want %0d", got.insert_total,
				want.insert_total));
	endtask

	bit calm = 1'b0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	bit hold_go = 1'b0;
	bit hold_done = 1'b0;

	function automatic int draw_idle(input int short_pct);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < short_pct)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid)
				take_item(in_data);
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (feed_q.size() > 0) begin
				in_data <= feed_q.pop_front();
				in_valid <= 1'b1;
				gap_left = draw_idle(70);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (hold_go && !hold_done) begin
			hold_left <= 400;
			hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			check_result(out_data);
		if (stall_left > 0)
			stall_left--;
		else
			stall_left = draw_idle(72);
		out_stall <= (hold_left > 0) || (stall_left > 0);
	end

	logic [7:0]  str_tmp [300];
	logic [63:0] pool_hash [256];
	logic [7:0]  pool_str [256][24];
	int          pool_len [256];
	int          pool_n = 0;
	int          items_queued = 0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic put_item(input logic [63:0] h, input logic [7:0] b, input bit hb,
			input bit last);
		in_item_t it;
		it.key_hash = h;
		it.data_byte = b;
		it.has_byte = hb;
		it.is_last = last;
		feed_q.push_back(it);
		items_queued++;
	endtask

	task automatic queue_string(input logic [63:0] h, input int len, input bit noisy);
		if (noisy)
			put_item(rand64(), 8'($urandom), 1'b0, 1'b0);
		if (len == 0) begin
			put_item(h, 8'($urandom), 1'b0, 1'b1);
			return;
		end
		for (int i = 0; i < len; i++) begin
			if (noisy && i == 1)
				put_item(rand64(), 8'($urandom), 1'b0, 1'b0);
			put_item(i == 0 ? h : rand64(), str_tmp[i], 1'b1, i == len - 1);
		end
	endtask

	task automatic random_string();
		int          r, k, len;
		logic [63:0] h;
		r = $urandom_range(0, 99);
		if (pool_n > 0 && r < 40) begin
			k = $urandom_range(0, pool_n - 1);
			h = pool_hash[k];
			len = pool_len[k];
			for (int i = 0; i < len; i++)
				str_tmp[i] = pool_str[k][i];
			if (r >= 34 && len < 24) begin
				str_tmp[len] = 8'($urandom);
				len++;
			end
		end else begin
			h = rand64();
			if (pool_n > 0 && r < 52)
				h[15:0] = pool_hash[$urandom_range(0, pool_n - 1)][15:0];
			len = (r == 99) ? $urandom_range(25, 270) : $urandom_range(0, 8);
			for (int i = 0; i < len; i++)
				str_tmp[i] = 8'($urandom);
			if (len <= 24 && pool_n < 256) begin
				pool_hash[pool_n] = h;
				pool_len[pool_n] = len;
				for (int i = 0; i < len; i++)
					pool_str[pool_n][i] = str_tmp[i];
				pool_n++;
			end
		end
		queue_string(h, len, $urandom_range(0, 9) == 0);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_SLOT_LOG2)
			log2_cfg = value[3:0];
		else
			cap_cfg = value[16:0];
	endtask

	task automatic wait_idle();
		while (!(feed_q.size() == 0 && !in_valid && lookup_q.size() == 0)) begin
			@(posedge clk);
			#1;
		end
		repeat (40) @(posedge clk);
	endtask

	int phase_log2 [7] = '{1, 0, 15, 4, 2, 10, 6};
	int phase_cap [7] = '{131071, 65536, 70000, -1, 0, 65536, 65536};

	initial begin
		for (int i = 0; i < 1024; i++)
			slot_mirror[i] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// zero tag at offset zero leaves its slot empty, so the same string lands twice
		queue_string(64'h5A5A_0000_0000_0000, 0, 1'b0);
		queue_string(64'h5A5A_0000_0000_0000, 0, 1'b0);
		queue_string(64'h5A5A_0000_0000_0000, 0, 1'b0);
		queue_string(64'h0, 0, 1'b0);
		str_tmp[0] = 8'hFF;
		str_tmp[1] = 8'h00;
		queue_string('1, 2, 1'b0);
		queue_string('1, 2, 1'b0);
		str_tmp[0] = 8'h41;
		queue_string(64'h1111_0000_0000_FFFF, 1, 1'b0);
		for (int i = 0; i < 257; i++)
			str_tmp[i] = 8'($urandom);
		queue_string(rand64(), 257, 1'b0);
		queue_string(rand64(), 3, 1'b1);
		wait_idle();

		for (int p = 0; p < 7; p++) begin
			write_reg(REG_SLOT_LOG2, phase_log2[p]);
			write_reg(REG_CAPACITY, phase_cap[p] < 0 ? fill_lvl + 60 : phase_cap[p]);
			calm = (p == 2 || p == 5);
			if (p == 3)
				hold_go <= 1'b1;
			items_queued = 0;
			while (items_queued < 18)
				random_string();
			wait_idle();
		end

		if (lookup_q.size() != 0)
			report("lookups left without a result");
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

// ===== sim.f =====
hdl/sih_pkg.sv
hdl/sih_datapath.sv
hdl/sih_ctrl.sv
hdl/string_intern_hash_table.sv
bench/testbench.sv
